@@ hdl/sha0mh_pkg.sv @@
`timescale 1ns / 1ps

package sha0mh_pkg;

  localparam int NUM_CV     = 5;
  localparam int CV_AW      = 3;
  localparam int MSG_WORDS  = 16;
  localparam int MSG_AW     = 4;
  localparam int NUM_ROUNDS = 80;

  typedef logic [31:0] word_t;

  localparam word_t K_R0 = 32'h5A827999;
  localparam word_t K_R1 = 32'h6ED9EBA1;
  localparam word_t K_R2 = 32'h8F1BBCDC;
  localparam word_t K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t cv_init(input logic [CV_AW-1:0] idx);
    word_t v;
    case (idx)
      3'd0: v = 32'h67452301;
      3'd1: v = 32'hEFCDAB89;
      3'd2: v = 32'h98BADCFE;
      3'd3: v = 32'h10325476;
      3'd4: v = 32'hC3D2E1F0;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input logic [6:0] rnd);
    word_t v;
    if (rnd < 7'd20) begin
      v = K_R0;
    end else if (rnd < 7'd40) begin
      v = K_R1;
    end else if (rnd < 7'd60) begin
      v = K_R2;
    end else begin
      v = K_R3;
    end
    return v;
  endfunction

  function automatic word_t round_f(input logic [6:0] rnd, input word_t b, input word_t c,
                                    input word_t d);
    word_t v;
    if (rnd < 7'd20) begin
      v = (b & c) | (~b & d);
    end else if (rnd >= 7'd40 && rnd < 7'd60) begin
      v = (b & c) | (b & d) | (c & d);
    end else begin
      v = b ^ c ^ d;
    end
    return v;
  endfunction

endpackage

@@ hdl/sha0mh_ram.sv @@
`timescale 1ns / 1ps

module sha0mh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/sha0_message_hasher.sv @@
`timescale 1ns / 1ps
// A byte beat is taken while idle; a beat that completes a 64-byte block starts a compression
// (load the chaining values, 80 rounds at one per cycle, write them back).
// End of message: padding (up to 18 writes), one or two compressions, then each digest
// word is read, captured and held until out_stall is low. in_stall is high unless idle.
// Reset: synchronous, active low; clears control state, chaining values read as the
// initial values until first written, no clearing pass.
module sha0_message_hasher
  import sha0mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_PAD     = 4'd1;
  localparam logic [3:0] ST_ZERO    = 4'd2;
  localparam logic [3:0] ST_LEN_HI  = 4'd3;
  localparam logic [3:0] ST_LEN_LO  = 4'd4;
  localparam logic [3:0] ST_CV_LOAD = 4'd5;
  localparam logic [3:0] ST_ROUND   = 4'd6;
  localparam logic [3:0] ST_CV_UPD  = 4'd7;
  localparam logic [3:0] ST_OUT_RD  = 4'd8;
  localparam logic [3:0] ST_OUT_CAP = 4'd9;
  localparam logic [3:0] ST_OUT_WAIT = 4'd10;

  localparam logic [1:0] AFT_IDLE = 2'd0;
  localparam logic [1:0] AFT_PAD  = 2'd1;
  localparam logic [1:0] AFT_ZERO = 2'd2;
  localparam logic [1:0] AFT_OUT  = 2'd3;

  localparam logic [4:0] LIMIT_ONE = 5'd14;
  localparam logic [4:0] LIMIT_TWO = 5'd16;
  localparam logic [MSG_AW-1:0] LEN_HI_ADDR = 4'd14;
  localparam logic [MSG_AW-1:0] LEN_LO_ADDR = 4'd15;
  localparam logic [CV_AW-1:0]  LAST_CV     = 3'(NUM_CV - 1);
  localparam logic [CV_AW-1:0]  CV_END      = 3'(NUM_CV);
  localparam logic [6:0]        LAST_ROUND  = 7'(NUM_ROUNDS - 1);

  logic [3:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [60:0] bytes_r, bytes_nxt;
  logic [4:0]  widx_r, widx_nxt;
  logic        two_blk_r, two_blk_nxt;
  logic [1:0]  after_r, after_nxt;
  logic [CV_AW-1:0] cnt_r, cnt_nxt;
  logic [6:0]  round_r, round_nxt;
  logic        fresh_r, fresh_nxt;
  word_t       a_r, b_r, c_r, d_r, e_r;
  word_t       a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  word_t       sched_r [MSG_WORDS];
  word_t       sched_nxt [MSG_WORDS];
  logic        out_valid_r, out_valid_nxt;
  word_t       out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_last_r, out_last_nxt;

  logic              msg_we;
  logic [MSG_AW-1:0] msg_waddr, msg_raddr;
  word_t             msg_wdata, msg_rdata;
  logic              cv_we;
  logic [CV_AW-1:0]  cv_waddr, cv_raddr;
  word_t             cv_wdata, cv_rdata;

  word_t       pad_word, w_cur, cv_base, tmp;
  logic [4:0]  limit;
  logic [CV_AW-1:0] cnt_prev, cv_rd_sel;

  sha0mh_ram #(.WIDTH(32), .DEPTH(MSG_WORDS)) u_msg_ram (
    .clk     (clk),
    .wr_en   (msg_we),
    .wr_addr (msg_waddr),
    .wr_data (msg_wdata),
    .rd_addr (msg_raddr),
    .rd_data (msg_rdata)
  );

  sha0mh_ram #(.WIDTH(32), .DEPTH(NUM_CV)) u_cv_ram (
    .clk     (clk),
    .wr_en   (cv_we),
    .wr_addr (cv_waddr),
    .wr_data (cv_wdata),
    .rd_addr (cv_raddr),
    .rd_data (cv_rdata)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

  always_comb begin
    case (fill_r[1:0])
      2'd0: pad_word = {PAD_BYTE, 24'h0};
      2'd1: pad_word = {acc_r[7:0], PAD_BYTE, 16'h0};
      2'd2: pad_word = {acc_r[15:0], PAD_BYTE, 8'h0};
      2'd3: pad_word = {acc_r[23:0], PAD_BYTE};
      default: pad_word = '0;
    endcase
  end

  assign limit     = two_blk_r ? LIMIT_TWO : LIMIT_ONE;
  assign cnt_prev  = cnt_r - 3'd1;
  assign cv_rd_sel = (cnt_r < CV_END) ? cnt_r : '0;
  assign cv_base   = fresh_r ? cv_init(cnt_prev) : cv_rdata;
  assign w_cur     = (round_r < 7'(MSG_WORDS)) ? msg_rdata
                   : (sched_r[2] ^ sched_r[7] ^ sched_r[13] ^ sched_r[15]);
  assign tmp       = {a_r[26:0], a_r[31:27]} + round_f(round_r, b_r, c_r, d_r) + e_r
                   + w_cur + round_k(round_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    acc_nxt       = acc_r;
    bytes_nxt     = bytes_r;
    widx_nxt      = widx_r;
    two_blk_nxt   = two_blk_r;
    after_nxt     = after_r;
    cnt_nxt       = cnt_r;
    round_nxt     = round_r;
    fresh_nxt     = fresh_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    sched_nxt     = sched_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    msg_we        = 1'b0;
    msg_waddr     = fill_r[5:2];
    msg_wdata     = {acc_r, in_data_byte};
    msg_raddr     = '0;
    cv_we         = 1'b0;
    cv_waddr      = cnt_prev;
    cv_wdata      = cv_base + a_r;
    cv_raddr      = cv_rd_sel;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            msg_we    = (fill_r[1:0] == 2'd3);
            acc_nxt   = {acc_r[15:0], in_data_byte};
            fill_nxt  = fill_r + 6'd1;
            bytes_nxt = bytes_r + 61'd1;
            if (fill_r == 6'd63) begin
              state_nxt = ST_CV_LOAD;
              cnt_nxt   = '0;
              after_nxt = in_end_of_message ? AFT_PAD : AFT_IDLE;
            end else if (in_end_of_message) begin
              state_nxt = ST_PAD;
            end
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        msg_we      = 1'b1;
        msg_wdata   = pad_word;
        widx_nxt    = {1'b0, fill_r[5:2]} + 5'd1;
        two_blk_nxt = (fill_r >= 6'd56);
        state_nxt   = ST_ZERO;
      end
      ST_ZERO: begin
        if (widx_r == limit) begin
          if (two_blk_r) begin
            state_nxt = ST_CV_LOAD;
            cnt_nxt   = '0;
            after_nxt = AFT_ZERO;
          end else begin
            state_nxt = ST_LEN_HI;
          end
        end else begin
          msg_we    = 1'b1;
          msg_waddr = widx_r[MSG_AW-1:0];
          msg_wdata = '0;
          widx_nxt  = widx_r + 5'd1;
        end
      end
      ST_LEN_HI: begin
        msg_we    = 1'b1;
        msg_waddr = LEN_HI_ADDR;
        msg_wdata = bytes_r[60:29];
        state_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        msg_we    = 1'b1;
        msg_waddr = LEN_LO_ADDR;
        msg_wdata = {bytes_r[28:0], 3'b000};
        state_nxt = ST_CV_LOAD;
        cnt_nxt   = '0;
        after_nxt = AFT_OUT;
      end
      ST_CV_LOAD: begin
        if (cnt_r != '0) begin
          a_nxt = b_r;
          b_nxt = c_r;
          c_nxt = d_r;
          d_nxt = e_r;
          e_nxt = cv_base;
        end
        if (cnt_r == CV_END) begin
          msg_raddr = '0;
          round_nxt = '0;
          state_nxt = ST_ROUND;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_ROUND: begin
        msg_raddr    = round_r[MSG_AW-1:0] + 4'd1;
        sched_nxt[0] = w_cur;
        for (int i = 1; i < MSG_WORDS; i++) begin
          sched_nxt[i] = sched_r[i-1];
        end
        a_nxt = tmp;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_CV_UPD;
          cnt_nxt   = '0;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end
      ST_CV_UPD: begin
        if (cnt_r != '0) begin
          cv_we = 1'b1;
          a_nxt = b_r;
          b_nxt = c_r;
          c_nxt = d_r;
          d_nxt = e_r;
          e_nxt = a_r;
        end
        if (cnt_r == CV_END) begin
          fresh_nxt = 1'b0;
          cnt_nxt   = '0;
          case (after_r)
            AFT_IDLE: state_nxt = ST_IDLE;
            AFT_PAD:  state_nxt = ST_PAD;
            AFT_ZERO: begin
              state_nxt   = ST_ZERO;
              widx_nxt    = '0;
              two_blk_nxt = 1'b0;
            end
            AFT_OUT:  state_nxt = ST_OUT_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_CAP;
      end
      ST_OUT_CAP: begin
        out_word_nxt  = cv_rdata;
        out_idx_nxt   = cnt_r;
        out_last_nxt  = (cnt_r == LAST_CV);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (cnt_r == LAST_CV) begin
            fresh_nxt = 1'b1;
            bytes_nxt = '0;
            fill_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bytes_r     <= '0;
      widx_r      <= '0;
      two_blk_r   <= 1'b0;
      after_r     <= AFT_IDLE;
      cnt_r       <= '0;
      round_r     <= '0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bytes_r     <= bytes_nxt;
      widx_r      <= widx_nxt;
      two_blk_r   <= two_blk_nxt;
      after_r     <= after_nxt;
      cnt_r       <= cnt_nxt;
      round_r     <= round_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    sched_r    <= sched_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (round_r <= LAST_ROUND))
    else $error("round counter out of range");

  a_out_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_OUT_WAIT))
    else $error("output beat outside output wait");

  a_cv_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cv_we |-> (cv_waddr != cv_raddr))
    else $error("chaining value read and write hit the same entry");

  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND || state_r == ST_CV_LOAD) |-> !msg_we)
    else $error("message memory written during compression");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=>
      (state_r == ST_IDLE && fill_r == '0 && bytes_r == '0 && fresh_r))
    else $error("message state not cleared after last digest word");
`endif

endmodule
